/* rtl/core/rsfr_pkg.sv */
// shared types and constants for the rc servo frame receiver
// no dependencies; the parser, decode, top level and checker refer to this package by scoped names
package rsfr_pkg;

	localparam logic [7:0]  HDR_FIRST  = 8'h20;
	localparam logic [7:0]  HDR_SECOND = 8'h40;
	localparam logic [15:0] CHECK_INIT = 16'hFFFF;
	localparam logic [15:0] SW3_LOW    = 16'd1250;
	localparam logic [15:0] SW3_HIGH   = 16'd1750;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

	localparam logic [1:0] KIND_CHANNEL = 2'd0;
	localparam logic [1:0] KIND_ERROR   = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	localparam logic         CMD_BYTE = 1'b0;
	localparam logic         CMD_TICK = 1'b1;

	// frame completion event from the parser
	typedef struct packed {
		logic done;
		logic good;
	} frame_evt_t;

	// decoded channel fields
	typedef struct packed {
		logic        [15:0] raw;
		logic signed [15:0] stick;
		logic               sw_two;
		logic        [1:0]  sw_three;
	} chan_res_t;

endpackage

/* rtl/core/rsfr_stream_if.sv */
// valid/ready channel interfaces for input items and result items
// depends on nothing; used by the top level and the testbench
interface rsfr_item_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface rsfr_result_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  kind;
	logic        [3:0]  channel_index;
	logic        [15:0] raw_value;
	logic signed [15:0] stick_value;
	logic               switch_two;
	logic        [1:0]  switch_three;
	logic               online;
	logic        [31:0] valid_frames;
	logic        [31:0] checksum_errors;
	logic               last;

	modport source (output valid, output kind, output channel_index, output raw_value,
		output stick_value, output switch_two, output switch_three, output online,
		output valid_frames, output checksum_errors, output last, input ready);
	modport sink (input valid, input kind, input channel_index, input raw_value,
		input stick_value, input switch_two, input switch_three, input online,
		input valid_frames, input checksum_errors, input last, output ready);
endinterface

/* rtl/core/rsfr_frame_parser.sv */
// byte parser: header hunt, running checksum, channel word writes into the channel store
// depends on rsfr_pkg
module rsfr_frame_parser #(
	parameter int CHANNELS = 14,
	parameter int IDX_W    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_en,
	input  logic [7:0]           rx_byte,
	output rsfr_pkg::frame_evt_t evt,
	output logic                 wr_en,
	output logic [IDX_W-1:0]     wr_addr,
	output logic [15:0]          wr_data
);

	localparam int FRAME_LEN = 2 * CHANNELS + 4;
	localparam int POS_W     = $clog2(FRAME_LEN);
	localparam logic [POS_W-1:0] POS_SECOND = POS_W'(1);
	localparam logic [POS_W-1:0] POS_FIRST_CH = POS_W'(2);
	localparam logic [POS_W-1:0] POS_TRAIL = POS_W'(FRAME_LEN - 2);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      acc_q, acc_d;
	logic [7:0]       low_q, low_d;
	logic [POS_W-1:0] byte_k;

	// offset of the byte within the channel/trailer area
	assign byte_k  = pos_q - POS_FIRST_CH;
	assign wr_addr = IDX_W'(byte_k >> 1);
	assign wr_data = {rx_byte, low_q};

	always_comb begin
		pos_d = pos_q;
		acc_d = acc_q;
		low_d = low_q;
		wr_en = 1'b0;
		evt   = '0;
		if (byte_en) begin
			if (pos_q == '0) begin
				if (rx_byte == rsfr_pkg::HDR_FIRST) begin
					pos_d = POS_SECOND;
					acc_d = {8'h00, rsfr_pkg::HDR_FIRST};
				end
			end else if (pos_q == POS_SECOND) begin
				if (rx_byte == rsfr_pkg::HDR_SECOND) begin
					pos_d = POS_FIRST_CH;
					acc_d = acc_q + {8'h00, rx_byte};
				end else if (rx_byte != rsfr_pkg::HDR_FIRST) begin
					pos_d = '0;
				end
			end else if (pos_q == POS_LAST) begin
				pos_d    = '0;
				evt.done = 1'b1;
				evt.good = (rsfr_pkg::CHECK_INIT - acc_q) == {rx_byte, low_q};
			end else begin
				pos_d = pos_q + POS_W'(1);
				if (!byte_k[0]) low_d = rx_byte;
				else wr_en = 1'b1;
				// the trailer is not part of the sum
				if (pos_q < POS_TRAIL) acc_d = acc_q + {8'h00, rx_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else begin
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		low_q <= low_d;
	end

endmodule

/* rtl/core/rsfr_chan_store.sv */
// channel value memory, one 16-bit word per channel, registered read port
// depends on nothing
module rsfr_chan_store #(
	parameter int DEPTH  = 14,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [15:0]       wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [15:0]       rdata
);

	// every entry is rewritten by a good frame before it is read back
	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/rsfr_chan_decode.sv */
// channel decode: center offset, deadband, saturation and switch positions
// depends on rsfr_pkg
module rsfr_chan_decode (
	input  logic                clk,
	input  logic                load,
	input  logic [15:0]         raw,
	input  logic [15:0]         center,
	input  logic [14:0]         deadband,
	output rsfr_pkg::chan_res_t res
);

	localparam logic signed [17:0] STICK_MAX = 18'sd32767;
	localparam logic signed [17:0] STICK_MIN = -18'sd32768;

	logic        [15:0] raw_s1;
	logic signed [17:0] diff_s1;
	logic               sw_two_s1;
	logic signed [17:0] db_ext;
	logic signed [17:0] val;

	always_ff @(posedge clk) begin
		if (load) begin
			raw_s1    <= raw;
			diff_s1   <= $signed({2'b00, raw}) - $signed({2'b00, center});
			sw_two_s1 <= raw > center;
		end
	end

	assign db_ext = $signed({3'b000, deadband});

	always_comb begin
		if (diff_s1 > db_ext) val = diff_s1 - db_ext;
		else if (diff_s1 < -db_ext) val = diff_s1 + db_ext;
		else val = '0;

		res.raw    = raw_s1;
		res.sw_two = sw_two_s1;
		if (val > STICK_MAX) res.stick = 16'sh7FFF;
		else if (val < STICK_MIN) res.stick = 16'sh8000;
		else res.stick = val[15:0];

		if (raw_s1 <= rsfr_pkg::SW3_LOW) res.sw_three = 2'd0;
		else if (raw_s1 <= rsfr_pkg::SW3_HIGH) res.sw_three = 2'd1;
		else res.sw_three = 2'd2;
	end

endmodule

/* rtl/core/rc_servo_frame_receiver.sv */
// top level of the rc servo frame receiver: control, counters, configuration, result register
// depends on rsfr_pkg, rsfr_stream_if, rsfr_frame_parser, rsfr_chan_store, rsfr_chan_decode
//
// Items are bytes or millisecond ticks. A byte that does not end a frame is taken and the
// block is ready again at once. A tick or a frame with a bad checksum holds the input in
// the status or error state and yields one result. A good frame holds the input while
// each channel goes through a read of the channel memory, a register of the decode unit
// and the result register. A stalled result port holds the block in those states until
// the result register is free. The result register lets the next item in while the
// previous result is still waiting.
module rc_servo_frame_receiver #(
	parameter int CHANNELS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rsfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	rsfr_item_if.sink                         item,
	rsfr_result_if.source                     result
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_STATUS = 6'b000010,
		ST_ERROR  = 6'b000100,
		ST_READ   = 6'b001000,
		ST_CALC   = 6'b010000,
		ST_PUT    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [15:0] center_q;
	logic [14:0] deadband_q;
	logic [31:0] timeout_q;
	logic [31:0] elapsed_q;
	logic [31:0] good_q;
	logic [31:0] bad_q;
	logic        seen_q;
	logic [IDX_W-1:0] idx_q;

	logic               res_valid_q;
	logic [1:0]         res_kind_q;
	logic [3:0]         res_index_q;
	logic [15:0]        res_raw_q;
	logic signed [15:0] res_stick_q;
	logic               res_sw_two_q;
	logic [1:0]         res_sw_three_q;
	logic               res_online_q;
	logic [31:0]        res_good_q;
	logic [31:0]        res_bad_q;
	logic               res_last_q;

	logic                 accept;
	logic                 byte_en;
	logic                 tick_en;
	logic                 slot_free;
	logic                 online;
	logic                 put_load;
	rsfr_pkg::frame_evt_t evt;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [15:0]          wr_data;
	logic [15:0]          rd_data;
	rsfr_pkg::chan_res_t  chan;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign byte_en    = accept && (item.command == rsfr_pkg::CMD_BYTE);
	assign tick_en    = accept && (item.command == rsfr_pkg::CMD_TICK);
	assign slot_free  = !res_valid_q || result.ready;
	assign online     = seen_q && (elapsed_q <= timeout_q);

	rsfr_frame_parser #(.CHANNELS(CHANNELS), .IDX_W(IDX_W)) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_en),
		.rx_byte (item.rx_byte),
		.evt     (evt),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	rsfr_chan_store #(.DEPTH(CHANNELS), .ADDR_W(IDX_W)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (state_q == ST_READ),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	rsfr_chan_decode u_decode (
		.clk      (clk),
		.load     (state_q == ST_CALC),
		.raw      (rd_data),
		.center   (center_q),
		.deadband (deadband_q),
		.res      (chan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q   <= 16'd1500;
			deadband_q <= 15'd20;
			timeout_q  <= 32'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsfr_pkg::CFG_CENTER:   center_q   <= cfg_wdata[15:0];
				rsfr_pkg::CFG_DEADBAND: deadband_q <= cfg_wdata[14:0];
				rsfr_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			good_q    <= '0;
			bad_q     <= '0;
			seen_q    <= 1'b0;
		end else begin
			if (tick_en && (elapsed_q != '1)) elapsed_q <= elapsed_q + 32'd1;
			if (evt.done && evt.good) begin
				elapsed_q <= '0;
				good_q    <= good_q + 32'd1;
				seen_q    <= 1'b1;
			end
			if (evt.done && !evt.good) bad_q <= bad_q + 32'd1;
		end
	end

	always_comb begin
		state_d  = state_q;
		put_load = 1'b0;
		unique case (state_q) inside
			ST_IDLE: begin
				if (tick_en) state_d = ST_STATUS;
				else if (evt.done) state_d = evt.good ? ST_READ : ST_ERROR;
			end
			ST_STATUS, ST_ERROR: begin
				if (slot_free) begin
					put_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: state_d = ST_CALC;
			ST_CALC: state_d = ST_PUT;
			ST_PUT: begin
				if (slot_free) begin
					put_load = 1'b1;
					state_d  = (idx_q == IDX_LAST) ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) idx_q <= '0;
			else if (state_q == ST_PUT && put_load) idx_q <= idx_q + IDX_W'(1);
			if (put_load) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put_load) begin
			res_online_q <= online;
			res_good_q   <= good_q;
			res_bad_q    <= bad_q;
			if (state_q == ST_PUT) begin
				res_kind_q     <= rsfr_pkg::KIND_CHANNEL;
				res_index_q    <= 4'(idx_q);
				res_raw_q      <= chan.raw;
				res_stick_q    <= chan.stick;
				res_sw_two_q   <= chan.sw_two;
				res_sw_three_q <= chan.sw_three;
				res_last_q     <= (idx_q == IDX_LAST);
			end else begin
				res_kind_q     <= (state_q == ST_STATUS) ? rsfr_pkg::KIND_STATUS
					: rsfr_pkg::KIND_ERROR;
				res_index_q    <= '0;
				res_raw_q      <= '0;
				res_stick_q    <= '0;
				res_sw_two_q   <= 1'b0;
				res_sw_three_q <= '0;
				res_last_q     <= 1'b1;
			end
		end
	end

	// the next frame can finish while a result waits, so the counters go with the result
	assign result.valid           = res_valid_q;
	assign result.kind            = res_kind_q;
	assign result.channel_index   = res_index_q;
	assign result.raw_value       = res_raw_q;
	assign result.stick_value     = res_stick_q;
	assign result.switch_two      = res_sw_two_q;
	assign result.switch_three    = res_sw_three_q;
	assign result.online          = res_online_q;
	assign result.valid_frames    = res_good_q;
	assign result.checksum_errors = res_bad_q;
	assign result.last            = res_last_q;

endmodule

/* rtl/core/rsfr_checker.sv */
// port-level checks for the rc servo frame receiver, attached by bind
// depends on rsfr_pkg and the top level rc_servo_frame_receiver
module rsfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        item_command,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_kind,
	input logic        res_online,
	input logic        res_last,
	input logic [15:0] res_raw
);

	// a result that is held back keeps its raw value and kind
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_raw) && $stable(res_kind))
		else $error("stalled result changed");

	// status and error results stand alone
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind != rsfr_pkg::KIND_CHANNEL) |-> res_last)
		else $error("non-channel result without last");

	// channel results follow a good frame, which restarts the timeout
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == rsfr_pkg::KIND_CHANNEL) |-> res_online)
		else $error("channel result while offline");

	// a tick always produces a result, so the input pauses after it
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_command == rsfr_pkg::CMD_TICK) |=> !item_ready)
		else $error("input taken right after a tick");

endmodule

bind rc_servo_frame_receiver rsfr_checker u_rsfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_command (item.command),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_kind     (result.kind),
	.res_online   (result.online),
	.res_last     (result.last),
	.res_raw      (result.raw_value)
);

/* tb/sv/rc_servo_frame_receiver_tb.sv */
// self-checking testbench for rc_servo_frame_receiver: byte and tick items in, channel,
// checksum error and link status results out, checked against a behavioral predictor
// depends on rsfr_pkg, rsfr_stream_if and the rc_servo_frame_receiver rtl
module rc_servo_frame_receiver_tb;

	localparam int CHANNELS      = 14;
	localparam int FRAME_LEN     = 2 * CHANNELS + 4;
	localparam int SETTLE_CYCLES = 3 * CHANNELS + 8;
	localparam int LONG_HOLD     = 400;

	typedef logic [15:0] chan_set_t [CHANNELS];
	typedef logic [7:0] frame_bytes_t [FRAME_LEN];

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  channel_index;
		logic [15:0] raw_value;
		logic [15:0] stick_value;
		logic        switch_two;
		logic [1:0]  switch_three;
		logic        online;
		logic [31:0] valid_frames;
		logic [31:0] checksum_errors;
		logic        last;
	} servo_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [rsfr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rsfr_pkg::CFG_DATA_W-1:0] cfg_wdata;

	rsfr_item_if item_if ();
	rsfr_result_if result_if ();

	rc_servo_frame_receiver #(.CHANNELS(CHANNELS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item(item_if),
		.result(result_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor copy of configuration and receiver state
	logic [15:0] center_reg   = 16'd1500;
	logic [14:0] deadband_reg = 15'd20;
	logic [31:0] timeout_reg  = 32'd100;
	int unsigned frame_pos    = 0;
	logic [7:0]  frame_buf [FRAME_LEN];
	logic [15:0] channel_vals [CHANNELS];
	logic [31:0] elapsed_ms   = '0;
	logic [31:0] good_frames  = '0;
	logic [31:0] bad_frames   = '0;
	bit          frame_seen   = 1'b0;

	servo_result_t pending_results [$];
	int fail_count     = 0;
	int accepted_items = 0;
	int tx_idle_pct    = 0;
	int rx_stall_pct   = 0;
	int hold_cycles    = 0;

	function automatic servo_result_t common_fields(logic [1:0] kind);
		servo_result_t r;
		r = '{default: '0};
		r.kind = kind;
		r.online = frame_seen && (elapsed_ms <= timeout_reg);
		r.valid_frames = good_frames;
		r.checksum_errors = bad_frames;
		return r;
	endfunction

	function automatic logic [15:0] stick_of(logic [15:0] raw);
		int d, db, v;
		d = int'(raw) - int'(center_reg);
		db = int'(deadband_reg);
		if (d > db) begin
			v = d - db;
		end else if (d < -db) begin
			v = d + db;
		end else begin
			v = 0;
		end
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// advances the predictor by one accepted item and queues the results it causes
	function automatic void predict_item(logic cmd, logic [7:0] b);
		servo_result_t r;
		logic [15:0] sum, trailer, raw;
		int i;
		if (cmd == rsfr_pkg::CMD_TICK) begin
			if (elapsed_ms != '1) elapsed_ms++;
			r = common_fields(rsfr_pkg::KIND_STATUS);
			r.last = 1'b1;
			pending_results.push_back(r);
			return;
		end
		if (frame_pos == 0) begin
			if (b == rsfr_pkg::HDR_FIRST) begin
				frame_buf[0] = b;
				frame_pos = 1;
			end
			return;
		end
		if (frame_pos == 1 && b != rsfr_pkg::HDR_SECOND) begin
			// a repeated first header byte keeps the hunt at the second byte
			if (b == rsfr_pkg::HDR_FIRST) begin
				frame_buf[0] = b;
			end else begin
				frame_pos = 0;
			end
			return;
		end
		frame_buf[frame_pos] = b;
		frame_pos++;
		if (frame_pos != FRAME_LEN) return;
		frame_pos = 0;
		sum = rsfr_pkg::CHECK_INIT;
		for (i = 0; i < FRAME_LEN - 2; i++) sum -= 16'(frame_buf[i]);
		trailer = {frame_buf[FRAME_LEN-1], frame_buf[FRAME_LEN-2]};
		if (sum != trailer) begin
			bad_frames++;
			r = common_fields(rsfr_pkg::KIND_ERROR);
			r.last = 1'b1;
			pending_results.push_back(r);
			return;
		end
		for (i = 0; i < CHANNELS; i++) channel_vals[i] = {frame_buf[3+2*i], frame_buf[2+2*i]};
		elapsed_ms = '0;
		good_frames++;
		frame_seen = 1'b1;
		for (i = 0; i < CHANNELS; i++) begin
			raw = channel_vals[i];
			r = common_fields(rsfr_pkg::KIND_CHANNEL);
			r.channel_index = 4'(i);
			r.raw_value = raw;
			r.stick_value = stick_of(raw);
			r.switch_two = raw > center_reg;
			r.switch_three = (raw <= rsfr_pkg::SW3_LOW) ? 2'd0
				: (raw <= rsfr_pkg::SW3_HIGH) ? 2'd1 : 2'd2;
			r.last = (i == CHANNELS - 1);
			pending_results.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		servo_result_t want;
		if (result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation waiting: kind %0d", result_if.kind);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, result_if.kind);
				check_field("channel_index", want.channel_index, result_if.channel_index);
				check_field("raw_value", want.raw_value, result_if.raw_value);
				check_field("stick_value", want.stick_value, $unsigned(result_if.stick_value));
				check_field("switch_two", want.switch_two, result_if.switch_two);
				check_field("switch_three", want.switch_three, result_if.switch_three);
				check_field("online", want.online, result_if.online);
				check_field("valid_frames", want.valid_frames, result_if.valid_frames);
				check_field("checksum_errors", want.checksum_errors, result_if.checksum_errors);
				check_field("last", want.last, result_if.last);
			end
		end
	end

	// result side: random stalls plus a long hold-off set by the backpressure test
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				hold_cycles--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// called at a clock edge; valid stays high after the transfer until the next gap
	task automatic send_item(logic cmd, logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.command <= cmd;
		item_if.rx_byte <= b;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		accepted_items++;
		predict_item(cmd, b);
	endtask

	task automatic send_tick();
		send_item(rsfr_pkg::CMD_TICK, 8'($urandom_range(255)));
	endtask

	task automatic wait_idle();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called right after wait_idle
	task automatic write_config(logic [15:0] center, logic [14:0] deadband, logic [31:0] timeout);
		cfg_we <= 1'b1;
		cfg_index <= rsfr_pkg::CFG_CENTER;
		cfg_wdata <= 32'(center);
		@(posedge clk);
		center_reg = center;
		cfg_index <= rsfr_pkg::CFG_DEADBAND;
		cfg_wdata <= 32'(deadband);
		@(posedge clk);
		deadband_reg = deadband;
		cfg_index <= rsfr_pkg::CFG_TIMEOUT;
		cfg_wdata <= timeout;
		@(posedge clk);
		timeout_reg = timeout;
		cfg_we <= 1'b0;
	endtask

	// damage: 0 intact, 1 corrupted trailer, 2 one payload bit flipped
	task automatic send_frame(chan_set_t ch, int damage, int keep, bit with_ticks);
		frame_bytes_t fb;
		logic [15:0] sum;
		int i, pos;
		fb[0] = rsfr_pkg::HDR_FIRST;
		fb[1] = rsfr_pkg::HDR_SECOND;
		for (i = 0; i < CHANNELS; i++) begin
			fb[2+2*i] = ch[i][7:0];
			fb[3+2*i] = ch[i][15:8];
		end
		sum = rsfr_pkg::CHECK_INIT;
		for (i = 0; i < FRAME_LEN - 2; i++) sum -= 16'(fb[i]);
		fb[FRAME_LEN-2] = sum[7:0];
		fb[FRAME_LEN-1] = sum[15:8];
		if (damage == 1) begin
			pos = FRAME_LEN - 2 + $urandom_range(1);
			fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
		end else if (damage == 2) begin
			pos = $urandom_range(2, FRAME_LEN - 3);
			fb[pos] = fb[pos] ^ (8'd1 << $urandom_range(7));
		end
		for (i = 0; i < keep; i++) begin
			if (with_ticks && $urandom_range(19) == 0) send_tick();
			send_item(rsfr_pkg::CMD_BYTE, fb[i]);
		end
	endtask

	// pad with zero bytes until the parser is back to hunting
	task automatic align_parser();
		while (frame_pos > 1) send_item(rsfr_pkg::CMD_BYTE, 8'h00);
	endtask

	function automatic chan_set_t limit_channels();
		chan_set_t ch;
		ch = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd1250, 16'd1251, 16'd1750,
			16'd1751, 16'd1500, 16'd1520, 16'd1521, 16'd1480, 16'd1479, 16'd1000};
		return ch;
	endfunction

	function automatic chan_set_t random_channels();
		chan_set_t ch;
		int i, v;
		for (i = 0; i < CHANNELS; i++) begin
			case ($urandom_range(5))
				0: ch[i] = 16'($urandom);
				1: ch[i] = 16'($urandom_range(1000, 2000));
				2: begin
					// just inside or outside the deadband
					v = int'(deadband_reg) + int'($urandom_range(2)) - 1;
					v = $urandom_range(1) ? int'(center_reg) + v : int'(center_reg) - v;
					ch[i] = 16'(v);
				end
				3: begin
					case ($urandom_range(3))
						0: ch[i] = 16'h0000;
						1: ch[i] = 16'hFFFF;
						2: ch[i] = 16'h8000;
						default: ch[i] = 16'h7FFF;
					endcase
				end
				4: begin
					v = ($urandom_range(1) ? 1250 : 1750) + int'($urandom_range(2)) - 1;
					ch[i] = 16'(v);
				end
				default: ch[i] = center_reg + 16'($urandom_range(2)) - 16'd1;
			endcase
		end
		return ch;
	endfunction

	task automatic send_random_traffic(int n);
		chan_set_t ch;
		int target, sel, cnt;
		target = accepted_items + n;
		while (accepted_items < target) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				align_parser();
				ch = random_channels();
				send_frame(ch, ($urandom_range(4) == 0) ? 1 + $urandom_range(1) : 0, FRAME_LEN, 1);
			end else if (sel < 82) begin
				cnt = $urandom_range(1, 4);
				repeat (cnt) send_tick();
			end else if (sel < 92) begin
				cnt = $urandom_range(1, 6);
				repeat (cnt) send_item(rsfr_pkg::CMD_BYTE, 8'($urandom_range(255)));
			end else begin
				// truncated frame, completed later by padding
				align_parser();
				ch = random_channels();
				send_frame(ch, 0, $urandom_range(2, FRAME_LEN - 1), 1);
			end
		end
	endtask

	task automatic test_link_offline();
		send_tick();
		send_tick();
		wait_idle();
	endtask

	task automatic test_header_sync();
		send_item(rsfr_pkg::CMD_BYTE, rsfr_pkg::HDR_SECOND);
		send_item(rsfr_pkg::CMD_BYTE, rsfr_pkg::HDR_FIRST);
		send_item(rsfr_pkg::CMD_BYTE, 8'h41);
		send_item(rsfr_pkg::CMD_BYTE, rsfr_pkg::HDR_FIRST);
		send_item(rsfr_pkg::CMD_BYTE, rsfr_pkg::HDR_FIRST);
		send_frame(limit_channels(), 0, FRAME_LEN, 0);
		send_tick();
		wait_idle();
	endtask

	task automatic test_bad_checksum();
		chan_set_t ch;
		ch = random_channels();
		send_frame(ch, 1, FRAME_LEN, 0);
		ch = random_channels();
		send_frame(ch, 2, FRAME_LEN, 0);
		send_tick();
		wait_idle();
	endtask

	task automatic test_timeout_boundary();
		chan_set_t ch;
		write_config(16'd1500, 15'd20, 32'd3);
		ch = random_channels();
		send_frame(ch, 0, FRAME_LEN, 0);
		repeat (5) send_tick();
		wait_idle();
		write_config(16'd1500, 15'd20, 32'd0);
		send_frame(ch, 0, FRAME_LEN, 0);
		repeat (2) send_tick();
		wait_idle();
	endtask

	task automatic test_config_limits();
		write_config(16'h0000, 15'h0000, 32'hFFFF_FFFF);
		send_frame(limit_channels(), 0, FRAME_LEN, 0);
		repeat (2) send_tick();
		wait_idle();
		write_config(16'hFFFF, 15'h7FFF, 32'd0);
		send_frame(limit_channels(), 0, FRAME_LEN, 0);
		send_tick();
		wait_idle();
	endtask

	task automatic test_random_phases();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		write_config(16'd1500, 15'd20, 32'd100);
		send_random_traffic(40);
		wait_idle();

		tx_idle_pct = 73;
		write_config(16'($urandom_range(1000, 2000)), 15'($urandom_range(100)),
			32'($urandom_range(1, 10)));
		send_random_traffic(40);
		wait_idle();

		tx_idle_pct = 0;
		rx_stall_pct = 73;
		write_config(16'($urandom), 15'($urandom), 32'($urandom_range(8)));
		send_random_traffic(40);
		wait_idle();

		tx_idle_pct = 18;
		rx_stall_pct = 18;
		write_config(16'($urandom_range(1200, 1800)), 15'($urandom_range(300)),
			$urandom_range(1) ? 32'($urandom) : 32'($urandom_range(6)));
		send_random_traffic(40);
		wait_idle();
	endtask

	// result port held off while items keep coming, so the block backs up
	task automatic test_backpressure();
		chan_set_t ch;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		write_config(16'd1500, 15'd20, 32'd100);
		hold_cycles = LONG_HOLD;
		align_parser();
		ch = random_channels();
		send_frame(ch, 0, FRAME_LEN, 0);
		repeat (6) send_tick();
		ch = random_channels();
		send_frame(ch, 0, FRAME_LEN, 0);
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rsfr_pkg::CFG_CENTER;
		cfg_wdata = '0;
		item_if.valid = 1'b0;
		item_if.command = rsfr_pkg::CMD_BYTE;
		item_if.rx_byte = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_link_offline();
		test_header_sync();
		test_bad_checksum();
		test_timeout_boundary();
		test_config_limits();
		test_random_phases();
		test_backpressure();

		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
